FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define IRPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define IRPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Types and codes shared by the IR pulse-distance receiver.
// ----------------------------------------------------------------------------
package irpd_pkg;

  // Edge word codes
  localparam logic [1:0] MODE_FALL  = 2'd0;
  localparam logic [1:0] MODE_RISE  = 2'd1;
  localparam logic [1:0] MODE_REARM = 2'd2;

  // Receive phase codes
  localparam logic [1:0] PHASE_ARMED = 2'd0;
  localparam logic [1:0] PHASE_RECV  = 2'd1;
  localparam logic [1:0] PHASE_DONE  = 2'd2;

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_START_GAP_MIN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ONE_GAP_MAX   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_BITS  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] START_GAP_RESET = 8'd24;
  localparam logic [7:0] ONE_GAP_RESET   = 8'd4;
  localparam logic [7:0] CHANNEL_RESET   = 8'h00;

  // Checksum constants
  localparam logic [7:0] CSUM_SEED = 8'h0F;
  localparam logic [7:0] CSUM_MASK = 8'h3F;
  localparam logic [7:0] FIRST_BIT = 8'h80;

  typedef struct packed {
    logic [7:0] start_gap_min;
    logic [7:0] one_gap_max;
    logic [7:0] channel_bits;
  } irpd_cfg_t;

  typedef struct packed {
    logic [1:0] receive_phase;
    logic       byte_done;
    logic [7:0] byte_value;
    logic [1:0] byte_index;
    logic       frame_done;
    logic       checksum_ok;
  } irpd_result_t;

endpackage

FILE: rtl/core/irpd_if.sv
// ----------------------------------------------------------------------------
// irpd interfaces
// Valid/ready channels for edge words in and result words out.
// ----------------------------------------------------------------------------
interface irpd_edge_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] gap_ticks;

  modport source (output valid, output mode, output gap_ticks, input ready);
  modport sink   (input valid, input mode, input gap_ticks, output ready);
endinterface

interface irpd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] receive_phase;
  logic       byte_done;
  logic [7:0] byte_value;
  logic [1:0] byte_index;
  logic       frame_done;
  logic       checksum_ok;

  modport source (output valid, output receive_phase, output byte_done,
                  output byte_value, output byte_index, output frame_done,
                  output checksum_ok, input ready);
  modport sink   (input valid, input receive_phase, input byte_done,
                  input byte_value, input byte_index, input frame_done,
                  input checksum_ok, output ready);
endinterface

FILE: rtl/core/ir_pulse_distance_receiver.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_receiver
// Decodes a pulse-distance IR frame from timed line edges, one word per edge.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake     Payload
//  line_in   in   valid/ready   mode, gap_ticks
//  result    out  valid/ready   receive_phase, byte_done, byte_value,
//                               byte_index, frame_done, checksum_ok
//  cfg       in   cfg_we        cfg_index, cfg_data (no read-back)
//
//  One edge word in and one result word out per cycle, sustained while
//  the result side is ready. An edge word passes the input register, then
//  the result register fed by the decode step.
//  Reset (rst, synchronous) arms the receiver and loads the register defaults.
//  A stalled result holds the decode stage; the input register still takes
//  one more word while it is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ir_pulse_distance_receiver #(
  parameter int unsigned FRAME_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  irpd_edge_if.sink                      line_in,
  irpd_result_if.source                  result,
  input  logic                           cfg_we,
  input  logic [irpd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import irpd_pkg::*;

  irpd_cfg_t    cfg;
  logic         in_valid;
  logic [1:0]   in_mode;
  logic [7:0]   in_gap;
  logic         out_valid;
  irpd_result_t res;
  irpd_result_t res_next;
  logic         advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_gap_min <= START_GAP_RESET;
      cfg.one_gap_max   <= ONE_GAP_RESET;
      cfg.channel_bits  <= CHANNEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_GAP_MIN: cfg.start_gap_min <= cfg_data;
        REG_ONE_GAP_MAX:   cfg.one_gap_max   <= cfg_data;
        REG_CHANNEL_BITS:  cfg.channel_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode step runs when the result register is free
  assign advance       = in_valid && (!out_valid || result.ready);
  assign line_in.ready = !in_valid || !out_valid || result.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (line_in.ready) begin
      in_valid <= line_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (line_in.ready && line_in.valid) begin
      in_mode <= line_in.mode;
      in_gap  <= line_in.gap_ticks;
    end
  end

  irpd_decode #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (advance),
    .mode      (in_mode),
    .gap_ticks (in_gap),
    .res       (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.receive_phase = res.receive_phase;
  assign result.byte_done     = res.byte_done;
  assign result.byte_value    = res.byte_value;
  assign result.byte_index    = res.byte_index;
  assign result.frame_done    = res.frame_done;
  assign result.checksum_ok   = res.checksum_ok;

  // Checks
  `IRPD_ASSERT(a_frame_has_byte, out_valid |-> (!res.frame_done || res.byte_done), "frame_done without byte_done")
  `IRPD_ASSERT(a_ok_needs_frame, out_valid |-> (!res.checksum_ok || res.frame_done), "checksum_ok without frame_done")
  `IRPD_ASSERT(a_done_phase, (out_valid && res.frame_done) |-> (res.receive_phase == PHASE_DONE), "frame_done outside complete phase")
  `IRPD_ASSERT(a_full_stall, (in_valid && out_valid && !result.ready) |-> !line_in.ready, "input taken while both stages stalled")
  `IRPD_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

endmodule

FILE: rtl/core/irpd_decode.sv
// ----------------------------------------------------------------------------
// irpd_decode
// Frame state, bit assembly, byte store and checksum for one edge word.
// ----------------------------------------------------------------------------
module irpd_decode #(
  parameter int unsigned FRAME_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  irpd_pkg::irpd_cfg_t   cfg,
  input  logic                  take,
  input  logic [1:0]            mode,
  input  logic [7:0]            gap_ticks,
  output irpd_pkg::irpd_result_t res
);
  import irpd_pkg::*;

  localparam int unsigned POS_W = $clog2(FRAME_BYTES + 2);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_ARMED = POS_W'(FRAME_BYTES + 1);
  localparam int unsigned CSUM_BYTES = 4;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       bit_mask, bit_mask_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [7:0]       frame_store [CSUM_BYTES];

  logic [7:0] cur_mask;
  logic [7:0] cur_byte;
  logic       store_byte;
  logic [7:0] last_byte;
  logic [7:0] csum;

  // Bit assembly and checksum over the first three bytes, checked against
  // the fourth, which may be the byte just built
  always_comb begin
    cur_mask = (bit_mask == 8'h00) ? FIRST_BIT : bit_mask;
    cur_byte = (bit_mask == 8'h00) ? 8'h00 : shift_byte;
    if (gap_ticks < cfg.one_gap_max) begin
      cur_byte = cur_byte | cur_mask;
    end
    last_byte = (byte_position == POS_W'(CSUM_BYTES - 1)) ? cur_byte : frame_store[3];
    csum = ((frame_store[0] + frame_store[1] + frame_store[2] + CSUM_SEED) & CSUM_MASK)
           | cfg.channel_bits;
  end

  // Next state and result word
  always_comb begin
    byte_position_next = byte_position;
    bit_mask_next      = bit_mask;
    shift_byte_next    = shift_byte;
    store_byte         = 1'b0;
    res                = '0;
    priority if (mode == MODE_REARM) begin
      byte_position_next = POS_ARMED;
      bit_mask_next      = 8'h00;
      shift_byte_next    = 8'h00;
    end else if (mode == MODE_FALL) begin
      priority if (byte_position >= POS_ARMED) begin
        if (gap_ticks >= cfg.start_gap_min) begin
          byte_position_next = '0;
          bit_mask_next      = 8'h00;
        end
      end else if (byte_position < POS_LAST) begin
        bit_mask_next   = cur_mask >> 1;
        shift_byte_next = cur_byte;
        if (cur_mask == 8'h01) begin
          store_byte         = 1'b1;
          res.byte_done      = 1'b1;
          res.byte_value     = cur_byte;
          res.byte_index     = byte_position[1:0];
          byte_position_next = byte_position + POS_W'(1);
          if (byte_position_next == POS_LAST) begin
            res.frame_done  = 1'b1;
            res.checksum_ok = (csum == last_byte);
          end
        end
      end else begin
        // frame complete: hold until rearm
      end
    end else begin
      // rising edge and unused code: no effect
    end
    priority if (byte_position_next >= POS_ARMED) begin
      res.receive_phase = PHASE_ARMED;
    end else if (byte_position_next >= POS_LAST) begin
      res.receive_phase = PHASE_DONE;
    end else begin
      res.receive_phase = PHASE_RECV;
    end
  end

  // Advance frame state on each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_ARMED;
      bit_mask      <= 8'h00;
      shift_byte    <= 8'h00;
    end else if (take) begin
      byte_position <= byte_position_next;
      bit_mask      <= bit_mask_next;
      shift_byte    <= shift_byte_next;
    end
  end

  // Keep the bytes the checksum needs
  always_ff @(posedge clk) begin
    for (int i = 0; i < CSUM_BYTES; i++) begin
      if (take && store_byte && byte_position == POS_W'(i)) begin
        frame_store[i] <= cur_byte;
      end
    end
  end

endmodule

FILE: tb/sv/ir_pulse_distance_receiver_tb.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_receiver_tb
// Drives timed line edges into the IR receiver and checks every result word
// against an in-bench decoder. The run covers a short directed sequence,
// frames under extreme and random register settings, aborted and noisy
// frames, and a long result stall that backs up the edge channel.
// ----------------------------------------------------------------------------
module ir_pulse_distance_receiver_tb;
  import irpd_pkg::*;

  localparam int unsigned FRAME_BYTES = 4;
  localparam logic [2:0]  ARMED_POS   = 3'(FRAME_BYTES + 1);
  localparam int          ITEM_TARGET = 550;

  // Result-side stall styles
  localparam logic [1:0] STALL_NONE    = 2'd0;
  localparam logic [1:0] STALL_RANDOM  = 2'd1;
  localparam logic [1:0] STALL_PATTERN = 2'd2;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  irpd_edge_if   line_in ();
  irpd_result_if result ();

  ir_pulse_distance_receiver #(.FRAME_BYTES(FRAME_BYTES)) dut (
    .clk      (clk),
    .rst      (rst),
    .line_in  (line_in),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Decoder state and register copies, updated at the clock edge
  logic [2:0] frame_pos;
  logic [7:0] bit_sel;
  logic [7:0] byte_acc;
  logic [7:0] frame_bytes [FRAME_BYTES];
  logic [7:0] dec_start_min;
  logic [7:0] dec_one_max;
  logic [7:0] dec_channel;

  irpd_result_t awaited_results [$];

  // Settings the stimulus shapes its gaps from
  logic [7:0] cur_start_min = START_GAP_RESET;
  logic [7:0] cur_one_max   = ONE_GAP_RESET;
  logic [7:0] cur_channel   = CHANNEL_RESET;

  // Gaps for one directed byte, alternating one and zero
  logic [7:0] gap_seq [8] = '{8'd0, 8'd255, 8'd3, 8'd4, 8'd1, 8'd200, 8'd2, 8'd5};

  int errors        = 0;
  int words_checked = 0;
  int edges_sent    = 0;
  int frames_seen   = 0;
  int sums_matched  = 0;
  int settings_used = 1;

  // Sender burst control
  bit idle_on    = 1'b0;
  int burst_left = 0;

  // Result stall control
  logic [1:0]  stall_style = STALL_NONE;
  int unsigned hold_left   = 0;
  int unsigned stall_tick  = 0;

  // --------------------------------------------------------------------------
  // Decoder: one edge word in, one expected result word out
  // --------------------------------------------------------------------------
  function automatic irpd_result_t decode_edge(logic [1:0] m, logic [7:0] g);
    irpd_result_t r;
    logic [7:0]   sum;
    r = '0;
    if (m == MODE_REARM) begin
      frame_pos = ARMED_POS;
      bit_sel   = '0;
      byte_acc  = '0;
    end else if (m == MODE_FALL) begin
      if (frame_pos >= ARMED_POS) begin
        if (g >= dec_start_min) begin
          frame_pos = '0;
          bit_sel   = '0;
        end
      end else if (frame_pos < FRAME_BYTES) begin
        if (bit_sel == '0) begin
          bit_sel  = FIRST_BIT;
          byte_acc = '0;
        end
        if (g < dec_one_max) byte_acc = byte_acc | bit_sel;
        bit_sel = bit_sel >> 1;
        if (bit_sel == '0) begin
          frame_bytes[frame_pos] = byte_acc;
          r.byte_done  = 1'b1;
          r.byte_value = byte_acc;
          r.byte_index = frame_pos[1:0];
          frame_pos    = frame_pos + 3'd1;
          if (frame_pos == FRAME_BYTES) begin
            sum = ((frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + CSUM_SEED)
                   & CSUM_MASK) | dec_channel;
            r.frame_done  = 1'b1;
            r.checksum_ok = (sum == frame_bytes[3]);
          end
        end
      end
    end
    if (frame_pos >= ARMED_POS)        r.receive_phase = PHASE_ARMED;
    else if (frame_pos >= FRAME_BYTES) r.receive_phase = PHASE_DONE;
    else                               r.receive_phase = PHASE_RECV;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on result word %0d: %s = %0h, expected %0h",
             words_checked, field, got, want);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: track register writes, check result words, queue predictions
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    irpd_result_t want;
    if (rst) begin
      frame_pos     = ARMED_POS;
      bit_sel       = '0;
      byte_acc      = '0;
      dec_start_min = START_GAP_RESET;
      dec_one_max   = ONE_GAP_RESET;
      dec_channel   = CHANNEL_RESET;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_GAP_MIN: dec_start_min = cfg_data;
          REG_ONE_GAP_MAX:   dec_one_max   = cfg_data;
          REG_CHANNEL_BITS:  dec_channel   = cfg_data;
          default: ;
        endcase
      end
      // Check the outgoing word before queuing this edge's prediction
      if (result.valid && result.ready) begin
        if (awaited_results.size() == 0) begin
          $display("result word %0d arrived with nothing expected", words_checked);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (result.receive_phase !== want.receive_phase)
            report_mismatch("receive_phase", result.receive_phase, want.receive_phase);
          if (result.byte_done !== want.byte_done)
            report_mismatch("byte_done", result.byte_done, want.byte_done);
          if (result.byte_value !== want.byte_value)
            report_mismatch("byte_value", result.byte_value, want.byte_value);
          if (result.byte_index !== want.byte_index)
            report_mismatch("byte_index", result.byte_index, want.byte_index);
          if (result.frame_done !== want.frame_done)
            report_mismatch("frame_done", result.frame_done, want.frame_done);
          if (result.checksum_ok !== want.checksum_ok)
            report_mismatch("checksum_ok", result.checksum_ok, want.checksum_ok);
          if (want.frame_done) frames_seen++;
          if (want.checksum_ok) sums_matched++;
        end
        words_checked++;
      end
      if (line_in.valid && line_in.ready)
        awaited_results.push_back(decode_edge(line_in.mode, line_in.gap_ticks));
    end
  end

  // --------------------------------------------------------------------------
  // Result side: long hold when asked, otherwise the current stall style
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (hold_left != 0) begin
      result.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      case (stall_style)
        STALL_NONE:   result.ready <= 1'b1;
        STALL_RANDOM: result.ready <= ($urandom_range(0, 3) != 0);
        default:      result.ready <= (stall_tick % 9) > 3;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one edge word; hold valid across a burst, drop it between bursts
  task automatic send_edge(logic [1:0] m, logic [7:0] g);
    if (idle_on && burst_left == 0) begin
      line_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    line_in.valid     <= 1'b1;
    line_in.mode      <= m;
    line_in.gap_ticks <= g;
    do @(posedge clk); while (!line_in.ready);
    if (burst_left != 0) burst_left--;
    edges_sent++;
  endtask

  // Stop offering and wait until every expected word has come back; the
  // first edge lets the monitor queue the word accepted last
  task automatic drain;
    line_in.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; only called while idle
  task automatic apply_config(logic [7:0] start_min, logic [7:0] one_max,
                              logic [7:0] channel);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_GAP_MIN;
    cfg_data  <= start_min;
    @(posedge clk);
    cfg_index <= REG_ONE_GAP_MAX;
    cfg_data  <= one_max;
    @(posedge clk);
    cfg_index <= REG_CHANNEL_BITS;
    cfg_data  <= channel;
    @(posedge clk);
    cfg_we        <= 1'b0;
    cur_start_min = start_min;
    cur_one_max   = one_max;
    cur_channel   = channel;
    settings_used++;
  endtask

  function automatic logic [7:0] gap_for_bit(bit one);
    if (one && cur_one_max != 0) return 8'($urandom_range(0, cur_one_max - 1));
    return 8'($urandom_range(cur_one_max, 255));
  endfunction

  // Noise, rearm, start, 32 data bits with stray rising edges, then trailers.
  // abort_at below 32 cuts the frame with a rearm at that bit.
  task automatic send_frame(logic [31:0] payload, int abort_at);
    repeat ($urandom_range(0, 3))
      send_edge(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    send_edge(MODE_REARM, 8'($urandom_range(0, 255)));
    // Occasionally try a start that is too short first
    if (cur_start_min != 0 && $urandom_range(0, 7) == 0)
      send_edge(MODE_FALL, 8'($urandom_range(0, cur_start_min - 1)));
    send_edge(MODE_FALL, 8'($urandom_range(cur_start_min, 255)));
    for (int k = 0; k < 32; k++) begin
      if (k == abort_at) begin
        send_edge(MODE_REARM, 8'($urandom_range(0, 255)));
        return;
      end
      if ($urandom_range(0, 3) == 0)
        send_edge(MODE_RISE, 8'($urandom_range(0, 255)));
      send_edge(MODE_FALL, gap_for_bit(payload[31 - k]));
    end
    repeat ($urandom_range(0, 3))
      send_edge(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // Random data bytes with the last byte as checksum most of the time
  task automatic send_random_frame;
    logic [7:0]  b0, b1, b2, b3;
    int          abort_at;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    if ($urandom_range(0, 2) != 0)
      b3 = ((b0 + b1 + b2 + CSUM_SEED) & CSUM_MASK) | cur_channel;
    else
      b3 = 8'($urandom);
    abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : 32;
    send_frame({b0, b1, b2, b3}, abort_at);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default registers: ignored edges, short start, bit thresholds, rearm
  task automatic test_directed;
    idle_on     = 1'b0;
    stall_style <= STALL_NONE;
    send_edge(MODE_RISE, 8'd255);
    send_edge(2'd3, 8'd0);
    send_edge(MODE_FALL, 8'd0);
    send_edge(MODE_FALL, START_GAP_RESET - 8'd1);
    send_edge(MODE_FALL, START_GAP_RESET);
    send_edge(MODE_FALL, 8'd0);
    send_edge(MODE_FALL, ONE_GAP_RESET - 8'd1);
    send_edge(MODE_FALL, ONE_GAP_RESET);
    send_edge(MODE_RISE, 8'd255);
    send_edge(2'd3, 8'd255);
    send_edge(MODE_FALL, 8'd255);
    send_edge(MODE_REARM, 8'd0);
    send_edge(MODE_FALL, 8'd255);
    // One full byte, alternating one and zero
    foreach (gap_seq[i]) send_edge(MODE_FALL, gap_seq[i]);
    send_edge(MODE_REARM, 8'd255);
    send_edge(MODE_FALL, 8'd255);
    send_edge(MODE_REARM, 8'hAA);
    drain();
  endtask

  // Register extremes: start on any edge with nearly all ones, then the
  // longest start with all zeros, then a one threshold of 1 with all ones
  task automatic test_extreme_configs;
    idle_on     = 1'b1;
    stall_style <= STALL_RANDOM;
    apply_config(8'd0, 8'd255, 8'hFF);
    send_frame({8'h12, 8'h34, 8'h56, 8'hFF}, 32);
    send_random_frame();
    drain();
    stall_style <= STALL_PATTERN;
    apply_config(8'd255, 8'd0, 8'h00);
    send_frame(32'h0000_0000, 32);
    send_random_frame();
    drain();
    apply_config(8'd1, 8'd1, 8'hC0);
    send_frame(32'hFFFF_FFFF, 32);
    send_random_frame();
    drain();
  endtask

  // Hold the result side for a long stretch while edges keep coming
  task automatic test_backpressure;
    idle_on     = 1'b0;
    stall_style <= STALL_NONE;
    apply_config(START_GAP_RESET, ONE_GAP_RESET, 8'h05);
    hold_left <= 60;
    send_frame({8'hA5, 8'h5A, 8'h3C, 8'h00}, 32);
    drain();
  endtask

  // Random settings, two frames per setting, until the edge budget is spent
  task automatic test_random_frames;
    while (edges_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      stall_style <= 2'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 0)
        apply_config(8'($urandom_range(8, 40)), 8'($urandom_range(2, 10)),
                     8'($urandom));
      else
        apply_config(8'($urandom), 8'($urandom), 8'($urandom));
      repeat (2) send_random_frame();
      drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_START_GAP_MIN;
    cfg_data          = '0;
    line_in.valid     = 1'b0;
    line_in.mode      = MODE_RISE;
    line_in.gap_ticks = '0;
    result.ready      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_extreme_configs();
    test_backpressure();
    test_random_frames();
    drain();

    $display("sent %0d edge words, checked %0d result words", edges_sent, words_checked);
    $display("decoded %0d frames (%0d checksum matches) over %0d register settings",
             frames_seen, sums_matched, settings_used);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("ir_pulse_distance_receiver_tb: clean");
    end else begin
      $display("ir_pulse_distance_receiver_tb: errors");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #1200000;
    $display("timeout with %0d result words outstanding", awaited_results.size());
    $display("ir_pulse_distance_receiver_tb: errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/irpd_pkg.sv
rtl/core/irpd_if.sv
rtl/core/irpd_decode.sv
rtl/core/ir_pulse_distance_receiver.sv
tb/sv/ir_pulse_distance_receiver_tb.sv
